// ===== hdl/bptc_pkg.sv =====
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types and constants of the barometer compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

    typedef enum logic [2:0] {
        CFG_AC1     = 3'd0,
        CFG_AC2     = 3'd1,
        CFG_AC3     = 3'd2,
        CFG_AC4     = 3'd3,
        CFG_AC5_AC6 = 3'd4,
        CFG_B1      = 3'd5,
        CFG_B2      = 3'd6,
        CFG_MC_MD   = 3'd7
    } t_cfg_idx;

    localparam logic [15:0] RST_AC1     = 16'd408;
    localparam logic [15:0] RST_AC2     = 16'hFFB8;
    localparam logic [15:0] RST_AC3     = 16'hC7D1;
    localparam logic [15:0] RST_AC4     = 16'd32741;
    localparam logic [31:0] RST_AC5_AC6 = 32'd2146785905;
    localparam logic [15:0] RST_B1      = 16'd6190;
    localparam logic [15:0] RST_B2      = 16'd4;
    localparam logic [31:0] RST_MC_MD   = 32'd3724086068;

    localparam logic signed [29:0] C_B6_OFS   = 30'sd4000;
    localparam logic [31:0]        C_B4_OFS   = 32'd32768;
    localparam logic [15:0]        C_B7_SCALE = 16'd50000;
    localparam logic signed [12:0] C_P_K1     = 13'sd3038;
    localparam logic signed [13:0] C_P_K2     = -14'sd7357;
    localparam logic signed [17:0] C_P_K3     = 18'sd3791;

endpackage

// ===== hdl/baro_temp_pressure_compensate_unit.sv =====
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensate_unit
// Integer temperature and pressure compensation of a barometer, oversampling 0.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  input    | i_in_valid / o_in_ready    | i_raw_temp, i_raw_press
//  output   | o_out_valid / i_out_ready  | o_temp_tenths, o_press_pa,
//           |                            | o_div_error
//  config   | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One transaction per cycle is taken unless the pipeline is frozen. It has two
// bit-serial divider pipelines (27 and 32 stages) plus ten arithmetic stages.
// The whole pipeline advances together; it freezes only while the output
// register holds a result that is not taken. Reset clears the valid bits and
// loads the calibration words with their defaults.
module baro_temp_pressure_compensate_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_raw_temp,
    input  logic [15:0] i_raw_press,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_temp_tenths,
    output logic [31:0] o_press_pa,
    output logic        o_div_error,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // Calibration registers.
    logic [15:0] r_ac1, r_ac2, r_ac3, r_ac4, r_b1, r_b2;
    logic [31:0] r_ac56, r_mcmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1  <= bptc_pkg::RST_AC1;
            r_ac2  <= bptc_pkg::RST_AC2;
            r_ac3  <= bptc_pkg::RST_AC3;
            r_ac4  <= bptc_pkg::RST_AC4;
            r_ac56 <= bptc_pkg::RST_AC5_AC6;
            r_b1   <= bptc_pkg::RST_B1;
            r_b2   <= bptc_pkg::RST_B2;
            r_mcmd <= bptc_pkg::RST_MC_MD;
        end else if (i_cfg_we) begin
            unique case (bptc_pkg::t_cfg_idx'(i_cfg_idx))
                bptc_pkg::CFG_AC1:     r_ac1  <= i_cfg_data[15:0];
                bptc_pkg::CFG_AC2:     r_ac2  <= i_cfg_data[15:0];
                bptc_pkg::CFG_AC3:     r_ac3  <= i_cfg_data[15:0];
                bptc_pkg::CFG_AC4:     r_ac4  <= i_cfg_data[15:0];
                bptc_pkg::CFG_AC5_AC6: r_ac56 <= i_cfg_data;
                bptc_pkg::CFG_B1:      r_b1   <= i_cfg_data[15:0];
                bptc_pkg::CFG_B2:      r_b2   <= i_cfg_data[15:0];
                bptc_pkg::CFG_MC_MD:   r_mcmd <= i_cfg_data;
            endcase
        end
    end

    logic en;
    logic r_out_vld;
    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    // Stage 1: (UT - AC6) * AC5.
    logic signed [16:0] s1_diff;
    logic signed [33:0] s1_prod;
    logic               r1_vld;
    logic [31:0]        r1_m;
    logic [15:0]        r1_up;
    assign s1_diff = $signed({1'b0, i_raw_temp}) - $signed({1'b0, r_ac56[15:0]});
    assign s1_prod = s1_diff * $signed({1'b0, r_ac56[31:16]});

    // Stage 2: X1 and the temperature divisor.
    logic signed [16:0] s2_x1;
    logic signed [17:0] s2_den;
    logic               r2_vld;
    logic signed [16:0] r2_x1;
    logic signed [17:0] r2_den;
    logic [15:0]        r2_up;
    assign s2_x1  = $signed(r1_m[31:15]);
    assign s2_den = 18'(s2_x1) + 18'($signed(r_mcmd[15:0]));

    // Divider A operands: magnitudes of MC * 2048 and the divisor.
    logic signed [26:0] da_nums;
    logic [26:0]        da_num;
    logic [17:0]        da_den;
    logic               da_neg;
    logic [34:0]        da_side_in, da_side;
    logic [26:0]        da_quo;
    logic               da_vld;
    assign da_nums    = $signed({r_mcmd[31:16], 11'b0});
    assign da_num     = da_nums[26] ? 27'(-da_nums) : da_nums;
    assign da_den     = r2_den[17] ? 18'(-r2_den) : r2_den;
    assign da_neg     = da_nums[26] ^ r2_den[17];
    assign da_side_in = {r2_x1, r2_up, da_neg, (r2_den == 18'sd0)};

    bptc_udiv #(.N(27), .D(18), .S(35)) u_div_t (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r2_vld),
        .i_num  (da_num),
        .i_den  (da_den),
        .i_side (da_side_in),
        .o_vld  (da_vld),
        .o_quo  (da_quo),
        .o_side (da_side)
    );

    // Stage 3: B5, temperature and B6.
    logic signed [27:0] s3_x2;
    logic signed [28:0] s3_b5;
    logic signed [29:0] s3_b5r;
    logic               r3_vld, r3_err;
    logic [31:0]        r3_temp;
    logic signed [29:0] r3_b6;
    logic [15:0]        r3_up;
    assign s3_x2  = da_side[1] ? -$signed({1'b0, da_quo}) : $signed({1'b0, da_quo});
    assign s3_b5  = 29'($signed(da_side[34:18])) + 29'(s3_x2);
    assign s3_b5r = 30'(s3_b5) + 30'sd8;

    // Stage 4: products of B6.
    logic signed [59:0] s4_sq;
    logic signed [45:0] s4_ac2, s4_ac3;
    logic               r4_vld, r4_err;
    logic [31:0]        r4_temp, r4_sqw, r4_ac2, r4_ac3;
    logic [15:0]        r4_up;
    assign s4_sq  = 60'(r3_b6) * 60'(r3_b6);
    assign s4_ac2 = 46'($signed(r_ac2)) * 46'(r3_b6);
    assign s4_ac3 = 46'($signed(r_ac3)) * 46'(r3_b6);

    // Stage 5: B2 and B1 times the scaled square.
    logic signed [19:0] s5_sq;
    logic signed [35:0] s5_b2, s5_b1;
    logic               r5_vld, r5_err;
    logic [31:0]        r5_temp, r5_b2sq, r5_b1sq;
    logic signed [20:0] r5_x2a;
    logic signed [18:0] r5_x1c;
    logic [15:0]        r5_up;
    assign s5_sq = $signed(r4_sqw[31:12]);
    assign s5_b2 = 36'($signed(r_b2)) * 36'(s5_sq);
    assign s5_b1 = 36'($signed(r_b1)) * 36'(s5_sq);

    // Stage 6: B3 and the sensitivity term X3.
    logic signed [21:0] s6_x3;
    logic signed [22:0] s6_v;
    logic signed [22:0] s6_b3;
    logic signed [19:0] s6_s;
    logic               r6_vld, r6_err;
    logic [31:0]        r6_temp;
    logic signed [22:0] r6_b3;
    logic signed [17:0] r6_x3;
    logic [15:0]        r6_up;
    assign s6_x3 = 22'($signed(r5_b2sq[31:11])) + 22'(r5_x2a);
    assign s6_v  = 23'($signed({r_ac1, 2'b00})) + 23'(s6_x3) + 23'sd2;
    // Signed division by four truncates toward zero.
    assign s6_b3 = s6_v[22] ? ((s6_v + 23'sd3) >>> 2) : (s6_v >>> 2);
    assign s6_s  = 20'(r5_x1c) + 20'($signed(r5_b1sq[31:16])) + 20'sd2;

    // Stage 7: B4 and B7.
    logic [31:0] s7_t;
    logic [47:0] s7_b4p;
    logic [31:0] s7_diff;
    logic [47:0] s7_b7p;
    logic [16:0] s7_b4;
    logic        r7_vld, r7_err;
    logic [31:0] r7_temp, r7_b7;
    logic [16:0] r7_b4;
    assign s7_t    = 32'(r6_x3) + bptc_pkg::C_B4_OFS;
    assign s7_b4p  = 48'(r_ac4) * 48'(s7_t);
    assign s7_b4   = s7_b4p[31:15];
    assign s7_diff = {16'b0, r6_up} - 32'(r6_b3);
    assign s7_b7p  = 48'(s7_diff) * 48'(bptc_pkg::C_B7_SCALE);

    // Divider B: B7 * 2 / B4, or B7 / B4 then doubled when B7 has its top bit set.
    logic [31:0] db_num, db_quo;
    logic [33:0] db_side_in, db_side;
    logic        db_vld;
    assign db_num     = r7_b7[31] ? r7_b7 : {r7_b7[30:0], 1'b0};
    assign db_side_in = {r7_b7[31], r7_temp, r7_err};

    bptc_udiv #(.N(32), .D(17), .S(34)) u_div_p (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r7_vld),
        .i_num  (db_num),
        .i_den  (r7_b4),
        .i_side (db_side_in),
        .o_vld  (db_vld),
        .o_quo  (db_quo),
        .o_side (db_side)
    );

    // Stage 8: pressure products.
    logic signed [31:0] s8_p;
    logic signed [23:0] s8_ps;
    logic signed [47:0] s8_sq;
    logic signed [45:0] s8_m7;
    logic               r8_vld, r8_err;
    logic [31:0]        r8_temp, r8_sq, r8_m7;
    logic signed [31:0] r8_p;
    assign s8_p  = db_side[33] ? $signed({db_quo[30:0], 1'b0}) : $signed(db_quo);
    assign s8_ps = $signed(s8_p[31:8]);
    assign s8_sq = 48'(s8_ps) * 48'(s8_ps);
    assign s8_m7 = 46'(s8_p) * 46'(bptc_pkg::C_P_K2);

    // Stage 9: scale the square.
    logic signed [44:0] s9_a;
    logic               r9_vld, r9_err;
    logic [31:0]        r9_temp;
    logic signed [31:0] r9_p;
    logic signed [15:0] r9_a, r9_x2;
    assign s9_a = 45'($signed(r8_sq)) * 45'(bptc_pkg::C_P_K1);

    // Stage 10: final correction.
    logic signed [17:0] s10_s;
    logic [31:0]        s10_p;
    logic [31:0]        r_temp_o, r_press_o;
    logic               r_err_o;
    assign s10_s = 18'(r9_a) + 18'(r9_x2) + bptc_pkg::C_P_K3;
    assign s10_p = 32'(r9_p + 32'(s10_s >>> 4));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r9_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= i_in_valid;
            r2_vld    <= r1_vld;
            r3_vld    <= da_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            r8_vld    <= db_vld;
            r9_vld    <= r8_vld;
            r_out_vld <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_m      <= s1_prod[31:0];
            r1_up     <= i_raw_press;
            r2_x1     <= s2_x1;
            r2_den    <= s2_den;
            r2_up     <= r1_up;
            r3_err    <= da_side[0];
            r3_temp   <= 32'(s3_b5r >>> 4);
            r3_b6     <= 30'(s3_b5) - bptc_pkg::C_B6_OFS;
            r3_up     <= da_side[17:2];
            r4_err    <= r3_err;
            r4_temp   <= r3_temp;
            r4_sqw    <= s4_sq[31:0];
            r4_ac2    <= s4_ac2[31:0];
            r4_ac3    <= s4_ac3[31:0];
            r4_up     <= r3_up;
            r5_err    <= r4_err;
            r5_temp   <= r4_temp;
            r5_b2sq   <= s5_b2[31:0];
            r5_b1sq   <= s5_b1[31:0];
            r5_x2a    <= $signed(r4_ac2[31:11]);
            r5_x1c    <= $signed(r4_ac3[31:13]);
            r5_up     <= r4_up;
            r6_err    <= r5_err;
            r6_temp   <= r5_temp;
            r6_b3     <= s6_b3;
            r6_x3     <= 18'(s6_s >>> 2);
            r6_up     <= r5_up;
            r7_err    <= r6_err || (s7_b4 == 17'd0);
            r7_temp   <= r6_temp;
            r7_b7     <= s7_b7p[31:0];
            r7_b4     <= s7_b4;
            r8_err    <= db_side[0];
            r8_temp   <= db_side[32:1];
            r8_p      <= s8_p;
            r8_sq     <= s8_sq[31:0];
            r8_m7     <= s8_m7[31:0];
            r9_err    <= r8_err;
            r9_temp   <= r8_temp;
            r9_p      <= r8_p;
            r9_a      <= $signed(s9_a[31:16]);
            r9_x2     <= $signed(r8_m7[31:16]);
            r_err_o   <= r9_err;
            r_temp_o  <= r9_err ? 32'd0 : r9_temp;
            r_press_o <= r9_err ? 32'd0 : s10_p;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_temp_tenths = r_temp_o;
    assign o_press_pa    = r_press_o;
    assign o_div_error   = r_err_o;

    // An error result never carries nonzero data.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_div_error |-> o_temp_tenths == 32'd0 && o_press_pa == 32'd0)
        else $error("error result with nonzero data");

    // A zero pressure divisor is flagged before it reaches the divider.
    a_b4_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r7_vld && r7_b4 == 17'd0 |-> r7_err)
        else $error("zero B4 not flagged");

    // A frozen pipeline keeps its stage valid bits.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r3_vld) && $stable(r8_vld) && $stable(r9_vld))
        else $error("pipeline moved during stall");

endmodule

// ===== hdl/bptc_udiv.sv =====
// ----------------------------------------------------------------------------
// bptc_udiv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bptc_udiv #(
    parameter int N = 32,
    parameter int D = 17,
    parameter int S = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_vld,
    input  logic [N-1:0] i_num,
    input  logic [D-1:0] i_den,
    input  logic [S-1:0] i_side,
    output logic         o_vld,
    output logic [N-1:0] o_quo,
    output logic [S-1:0] o_side
);

    logic [N-1:0] r_num  [N];
    logic [D-1:0] r_rem  [N-1];
    logic [D-1:0] r_den  [N];
    logic [S-1:0] r_side [N];
    logic         r_vld  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [N-1:0] num_in;
        logic [D-1:0] rem_in;
        logic [D-1:0] den_in;
        logic [S-1:0] side_in;
        logic         vld_in;
        logic [D:0]   trial;
        logic [D:0]   diff;
        logic         ge;
        logic [D-1:0] n_rem;
        logic [N-1:0] n_num;

        if (k == 0) begin : g_first
            assign num_in  = i_num;
            assign rem_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
            assign vld_in  = i_vld;
        end else begin : g_next
            assign num_in  = r_num[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        always_comb begin
            trial = {rem_in, num_in[N-1]};
            diff  = trial - {1'b0, den_in};
            ge    = (trial >= {1'b0, den_in});
            n_rem = ge ? diff[D-1:0] : trial[D-1:0];
            n_num = {num_in[N-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= n_num;
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end

        if (k < N - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                end
            end
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_quo  = r_num[N-1];
    assign o_side = r_side[N-1];

endmodule
